FILE: hw/rtl/lrast_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared opcodes and controller-to-datapath command type for the line
// rasteriser.
// ----------------------------------------------------------------------------
package lrast_pkg;

   // Transaction opcodes on the request channel
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Commands from the controller to the datapath, at most one per cycle
   typedef struct packed {
      logic load;   // capture endpoints and colour of a start transaction
      logic setup;  // derive axes, lengths and first pixel
      logic emit;   // present current pixel and advance the walk
   } lrast_cmd_type;

endpackage : lrast_pkg
`default_nettype wire

FILE: hw/rtl/lrast_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_ctrl
// Sequencer for the line rasteriser: accepts one request transaction, issues
// load and setup (start only) and emit, then holds the response until taken.
// ----------------------------------------------------------------------------
module lrast_ctrl
   import lrast_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_opcode,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output lrast_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign req_take  = req_valid && !req_stall;

   assign cmd.load  = req_take && (req_opcode == OP_START);
   assign cmd.setup = (state_ff == ST_SETUP);
   assign cmd.emit  = (state_ff == ST_EMIT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_opcode == OP_START) ? ST_SETUP : ST_EMIT;
            end
         end
         ST_SETUP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A request is never taken while a response is pending
   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !rsp_valid)
      else $error("request taken while response pending");

   // A taken response is not presented again
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("response repeated");

   // Every emit produces a response in the next cycle
   a_emit_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emit without response");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.setup, cmd.emit}))
      else $error("overlapping datapath commands");

endmodule : lrast_ctrl
`default_nettype wire

FILE: hw/rtl/lrast_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_datapath
// Endpoint capture, axis and length derivation, error accumulator walk and
// the response register of the line rasteriser.
// ----------------------------------------------------------------------------
module lrast_datapath
   import lrast_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lrast_cmd_type                cmd,
   input  wire logic signed [COORD_BITS-1:0] req_x_start,
   input  wire logic signed [COORD_BITS-1:0] req_y_start,
   input  wire logic signed [COORD_BITS-1:0] req_x_end,
   input  wire logic signed [COORD_BITS-1:0] req_y_end,
   input  wire logic        [31:0]           req_line_color,
   output logic                              rsp_pixel_valid,
   output logic signed      [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed      [COORD_BITS-1:0] rsp_pixel_y,
   output logic             [31:0]           rsp_pixel_color,
   output logic                              rsp_last_pixel
);

   localparam int CB = COORD_BITS;

   // Captured endpoints
   logic signed [CB-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic        [31:0]   held_color_ff;

   // Walk state
   logic signed [CB-1:0] cur_x_ff, cur_y_ff, major_end_ff;
   logic        [CB-1:0] err_ff, major_len_ff, minor_len_ff;
   logic                 minor_down_ff, y_major_ff, drawing_ff;

   // Response register
   logic                 pix_valid_ff, pix_last_ff;
   logic signed [CB-1:0] pix_x_ff, pix_y_ff;
   logic        [31:0]   pix_color_ff;

   // Setup terms
   logic signed [CB:0]   dx_w, dy_w, dx_neg, dy_neg;
   logic        [CB-1:0] adx, ady;
   logic                 y_major, swap, minor_down;
   logic signed [CB-1:0] sx0, sy0, sx1, sy1;

   // Walk terms
   logic signed [CB-1:0] major_now;
   logic                 last;
   logic        [CB:0]   acc, acc_sub;
   logic                 wrap;
   logic        [CB-1:0] err_next;

   always_comb begin
      dx_w   = {x1_ff[CB-1], x1_ff} - {x0_ff[CB-1], x0_ff};
      dy_w   = {y1_ff[CB-1], y1_ff} - {y0_ff[CB-1], y0_ff};
      dx_neg = -dx_w;
      dy_neg = -dy_w;
      adx    = dx_w[CB] ? dx_neg[CB-1:0] : dx_w[CB-1:0];
      ady    = dy_w[CB] ? dy_neg[CB-1:0] : dy_w[CB-1:0];
      y_major = (ady > adx);
      swap    = y_major ? (y0_ff > y1_ff) : (x0_ff > x1_ff);
      sx0 = swap ? x1_ff : x0_ff;
      sy0 = swap ? y1_ff : y0_ff;
      sx1 = swap ? x0_ff : x1_ff;
      sy1 = swap ? y0_ff : y1_ff;
      minor_down = y_major ? (sx1 < sx0) : (sy1 < sy0);
   end

   always_comb begin
      major_now = y_major_ff ? cur_y_ff : cur_x_ff;
      last      = (major_now == major_end_ff);
      acc       = {1'b0, err_ff} + {1'b0, minor_len_ff};
      wrap      = (acc >= {1'b0, major_len_ff});
      acc_sub   = acc - {1'b0, major_len_ff};
      err_next  = wrap ? acc_sub[CB-1:0] : acc[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff         <= req_x_start;
         y0_ff         <= req_y_start;
         x1_ff         <= req_x_end;
         y1_ff         <= req_y_end;
         held_color_ff <= req_line_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drawing_ff <= 1'b0;
      end else if (cmd.setup) begin
         drawing_ff <= 1'b1;
      end else if (cmd.emit && drawing_ff && last) begin
         drawing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         cur_x_ff      <= sx0;
         cur_y_ff      <= sy0;
         major_end_ff  <= y_major ? sy1 : sx1;
         major_len_ff  <= y_major ? ady : adx;
         minor_len_ff  <= y_major ? adx : ady;
         minor_down_ff <= minor_down;
         y_major_ff    <= y_major;
         err_ff        <= '0;
      end else if (cmd.emit && drawing_ff && !last) begin
         err_ff <= err_next;
         if (y_major_ff) begin
            cur_y_ff <= cur_y_ff + CB'(1);
            if (wrap) begin
               cur_x_ff <= minor_down_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
            end
         end else begin
            cur_x_ff <= cur_x_ff + CB'(1);
            if (wrap) begin
               cur_y_ff <= minor_down_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (drawing_ff) begin
            pix_valid_ff <= 1'b1;
            pix_x_ff     <= cur_x_ff;
            pix_y_ff     <= cur_y_ff;
            pix_color_ff <= held_color_ff;
            pix_last_ff  <= last;
         end else begin
            pix_valid_ff <= 1'b0;
            pix_x_ff     <= '0;
            pix_y_ff     <= '0;
            pix_color_ff <= '0;
            pix_last_ff  <= 1'b0;
         end
      end
   end

   assign rsp_pixel_valid = pix_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_pixel_color = pix_color_ff;
   assign rsp_last_pixel  = pix_last_ff;

   // Accumulator stays below the major length while a line is walked
   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      drawing_ff && (major_len_ff != '0) |-> err_ff < major_len_ff)
      else $error("error accumulator out of range");

   // The final pixel ends the line
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && drawing_ff && last |=> !drawing_ff && pix_last_ff)
      else $error("line did not end on last pixel");

   // An idle step yields no pixel
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !drawing_ff |=> !pix_valid_ff && !pix_last_ff)
      else $error("pixel emitted while idle");

endmodule : lrast_datapath
`default_nettype wire

FILE: hw/rtl/line_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer
// Error accumulator line walker: one pixel response per request transaction.
// ----------------------------------------------------------------------------
// Send a start transaction (opcode 0) carrying both endpoints and a colour;
// its response is the first pixel of the line. Each step transaction
// (opcode 1) then returns the next pixel, with last_pixel set on the final
// one, after which the block is idle and a step returns pixel_valid low with
// all other fields zero. The major axis is the one with the longer extent
// (x on a tie) and the walk always counts upward along it, so an x-major line
// given right to left comes out from its left end. A start transaction abandons
// any line in progress. One transaction is in flight at a time: a step goes
// through accept, emit into the response register and hand-over before the
// next is accepted, and a start adds a setup state that forms the absolute
// extents, picks the major axis and orders the endpoints. A stalled response
// holds the request channel stalled as well.
// ----------------------------------------------------------------------------
module line_rasterizer
   import lrast_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_opcode,
   input  wire logic signed [COORD_BITS-1:0] req_x_start,
   input  wire logic signed [COORD_BITS-1:0] req_y_start,
   input  wire logic signed [COORD_BITS-1:0] req_x_end,
   input  wire logic signed [COORD_BITS-1:0] req_y_end,
   input  wire logic        [31:0]           req_line_color,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_pixel_valid,
   output logic signed      [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed      [COORD_BITS-1:0] rsp_pixel_y,
   output logic             [31:0]           rsp_pixel_color,
   output logic                              rsp_last_pixel
);

   // Commands from the sequencer to the datapath
   lrast_cmd_type cmd;

   // Sequencer: accept, optional setup, emit, hold the response
   lrast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   // Datapath: endpoint capture, walk state and response register
   lrast_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_line_color  (req_line_color),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   // The final pixel of a line always carries a valid pixel
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |-> rsp_pixel_valid)
      else $error("last pixel flagged without a pixel");

   // Response payload holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall) && !$past(reset) |->
         rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y))
      else $error("stalled response changed");

   // No request is taken in the cycle a response is presented
   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request channel open during response");

endmodule : line_rasterizer
`default_nettype wire
